// ----- design/alarm_deadline_table_timer_macros.svh -----
// ----------------------------------------------------------------------------
// Alarm deadline table timer: assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ALARM_DEADLINE_TABLE_TIMER_MACROS_SVH
`define ALARM_DEADLINE_TABLE_TIMER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define ADTT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("adtt assertion failed");

// next-cycle implication
`define ADTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("adtt assertion failed");

`else

`define ADTT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ADTT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/adtt_pkg.sv -----
// ----------------------------------------------------------------------------
// Alarm deadline table timer package
// Shared constants and table interface structs.
// ----------------------------------------------------------------------------
package adtt_pkg;

  localparam int SLOTS       = 64;
  localparam int MAX_RESULTS = 64;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  localparam int TIME_W  = 32;
  localparam int STEP_W  = 16;
  localparam int SLOT_W  = 6;
  localparam int OWNER_W = 8;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd7;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_ARM  = 1'b1;

  // table access from the sequencer
  typedef struct packed {
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [TIME_W-1:0]  wr_dl;
    logic [OWNER_W-1:0] wr_owner;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
    logic               clr_en;
    logic [IDX_W-1:0]   clr_idx;
  } tbl_req_t;

  // registered read data
  typedef struct packed {
    logic               vld;
    logic [TIME_W-1:0]  dl;
    logic [OWNER_W-1:0] owner;
  } tbl_rsp_t;

endpackage

// ----- design/adtt_table.sv -----
// ----------------------------------------------------------------------------
// Alarm slot table
// Deadline and owner memories with per-slot armed bits, registered read.
// ----------------------------------------------------------------------------
module adtt_table (
  input  logic               clk,
  input  logic               rst_n,
  input  adtt_pkg::tbl_req_t req,
  output adtt_pkg::tbl_rsp_t rsp
);

  logic [adtt_pkg::TIME_W-1:0]  dl_mem  [adtt_pkg::SLOTS];
  logic [adtt_pkg::OWNER_W-1:0] own_mem [adtt_pkg::SLOTS];
  logic [adtt_pkg::SLOTS-1:0]   vld_r;
  adtt_pkg::tbl_rsp_t           rsp_r;

  // armed bits: reset leaves every slot disarmed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_idx] <= 1'b1;
      end
      if (req.clr_en) begin
        vld_r[req.clr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      dl_mem[req.wr_idx]  <= req.wr_dl;
      own_mem[req.wr_idx] <= req.wr_owner;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rsp_r.vld   <= vld_r[req.rd_idx];
      rsp_r.dl    <= dl_mem[req.rd_idx];
      rsp_r.owner <= own_mem[req.rd_idx];
    end
  end

  assign rsp = rsp_r;

endmodule

// ----- design/alarm_deadline_table_timer.sv -----
// ----------------------------------------------------------------------------
// Alarm deadline table timer
// Time counter plus alarm slot table, scanned slot by slot on every tick.
// ----------------------------------------------------------------------------
// Arm: the slot is written on accept; the final result is registered from ST_EMIT.
// Tick: one slot per cycle through the table read port, checked from the registered
//   read data; new requests are taken only in ST_IDLE, after the final result.
// Output stalls hold the scan. Synchronous active-low reset: time 0, step 7,
// all slots disarmed at once; owner entries stay undefined until armed.
`include "alarm_deadline_table_timer_macros.svh"

module alarm_deadline_table_timer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [adtt_pkg::STEP_W-1:0]    cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [adtt_pkg::SLOT_W-1:0]    in_slot,
  input  logic [adtt_pkg::OWNER_W-1:0]   in_task_id,
  input  logic [adtt_pkg::TIME_W-1:0]    in_deadline,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_fired,
  output logic [adtt_pkg::SLOT_W-1:0]    out_fired_slot,
  output logic [adtt_pkg::OWNER_W-1:0]   out_fired_task,
  output logic [adtt_pkg::TIME_W-1:0]    out_time_now,
  output logic                           out_last
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                         state_r, state_nxt;
  logic [adtt_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic [adtt_pkg::TIME_W-1:0]    time_r, time_nxt;
  logic [adtt_pkg::CNT_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                           chk_v_r, chk_v_nxt;
  logic [adtt_pkg::IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic [adtt_pkg::RES_W-1:0]     cnt_r, cnt_nxt;
  logic                           pend_v_r, pend_v_nxt;
  logic [adtt_pkg::IDX_W-1:0]     pend_slot_r, pend_slot_nxt;
  logic [adtt_pkg::OWNER_W-1:0]   pend_owner_r, pend_owner_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic                           out_fired_r, out_fired_nxt;
  logic [adtt_pkg::SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [adtt_pkg::OWNER_W-1:0]   out_owner_r, out_owner_nxt;
  logic [adtt_pkg::TIME_W-1:0]    out_time_r, out_time_nxt;
  logic                           out_last_r, out_last_nxt;

  adtt_pkg::tbl_req_t             tbl_req;
  adtt_pkg::tbl_rsp_t             tbl_rsp;

  logic in_acc;
  logic out_free;
  logic due;
  logic blk;
  logic adv;
  logic issue;

  adtt_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .rsp   (tbl_rsp)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign due = chk_v_r && tbl_rsp.vld && (tbl_rsp.dl != '0) && (tbl_rsp.dl <= time_r) &&
               (cnt_r < adtt_pkg::RES_W'(adtt_pkg::MAX_RESULTS));
  // a second due slot needs the output register for the held one
  assign blk   = due && pend_v_r && !out_free;
  assign adv   = (state_r == ST_SCAN) && !blk;
  assign issue = adv && (rd_idx_r < adtt_pkg::CNT_W'(adtt_pkg::SLOTS));

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = cfg_wr_en ? cfg_wr_data : step_r;
    time_nxt       = time_r;
    rd_idx_nxt     = rd_idx_r;
    chk_v_nxt      = chk_v_r;
    chk_idx_nxt    = chk_idx_r;
    cnt_nxt        = cnt_r;
    pend_v_nxt     = pend_v_r;
    pend_slot_nxt  = pend_slot_r;
    pend_owner_nxt = pend_owner_r;

    out_valid_nxt  = out_valid_r && !out_ready;
    out_fired_nxt  = out_fired_r;
    out_slot_nxt   = out_slot_r;
    out_owner_nxt  = out_owner_r;
    out_time_nxt   = out_time_r;
    out_last_nxt   = out_last_r;

    tbl_req          = '0;
    tbl_req.wr_idx   = adtt_pkg::IDX_W'(in_slot);
    tbl_req.wr_dl    = in_deadline;
    tbl_req.wr_owner = in_task_id;
    tbl_req.rd_idx   = rd_idx_r[adtt_pkg::IDX_W-1:0];
    tbl_req.clr_idx  = chk_idx_r;
    tbl_req.rd_en    = issue;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pend_v_nxt = 1'b0;
          cnt_nxt    = '0;
          if (in_req_type == adtt_pkg::REQ_ARM) begin
            tbl_req.wr_en = (32'(in_slot) < 32'(adtt_pkg::SLOTS));
            state_nxt     = ST_EMIT;
          end else begin
            time_nxt   = time_r + adtt_pkg::TIME_W'(step_r);
            rd_idx_nxt = '0;
            chk_v_nxt  = 1'b0;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (adv) begin
          chk_v_nxt = issue;
          if (issue) begin
            rd_idx_nxt  = rd_idx_r + 1'b1;
            chk_idx_nxt = rd_idx_r[adtt_pkg::IDX_W-1:0];
          end
          if (due) begin
            tbl_req.clr_en = 1'b1;
            cnt_nxt        = cnt_r + 1'b1;
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_fired_nxt = 1'b1;
              out_slot_nxt  = adtt_pkg::SLOT_W'(pend_slot_r);
              out_owner_nxt = pend_owner_r;
              out_time_nxt  = time_r;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt     = 1'b1;
            pend_slot_nxt  = chk_idx_r;
            pend_owner_nxt = tbl_rsp.owner;
          end
          if (chk_v_r && (chk_idx_r == adtt_pkg::IDX_W'(adtt_pkg::SLOTS - 1))) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_fired_nxt = pend_v_r;
          out_slot_nxt  = pend_v_r ? adtt_pkg::SLOT_W'(pend_slot_r) : '0;
          out_owner_nxt = pend_v_r ? pend_owner_r : '0;
          out_time_nxt  = time_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= adtt_pkg::STEP_RESET;
      time_r      <= '0;
      rd_idx_r    <= '0;
      chk_v_r     <= 1'b0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      time_r      <= time_nxt;
      rd_idx_r    <= rd_idx_nxt;
      chk_v_r     <= chk_v_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r    <= chk_idx_nxt;
    pend_slot_r  <= pend_slot_nxt;
    pend_owner_r <= pend_owner_nxt;
    out_fired_r  <= out_fired_nxt;
    out_slot_r   <= out_slot_nxt;
    out_owner_r  <= out_owner_nxt;
    out_time_r   <= out_time_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_fired      = out_fired_r;
  assign out_fired_slot = out_slot_r;
  assign out_fired_task = out_owner_r;
  assign out_time_now   = out_time_r;
  assign out_last       = out_last_r;

  // a tick moves time by exactly the step in force
  `ADTT_ASSERT_NEXT(a_tick_time, clk, rst_n,
    in_acc && (in_req_type == adtt_pkg::REQ_TICK),
    time_r == ($past(time_r) + adtt_pkg::TIME_W'($past(step_r))))
  // a result without an alarm always closes its transaction
  `ADTT_ASSERT_NOW(a_empty_last, clk, rst_n,
    out_valid_r && !out_fired_r, out_last_r)
  // an arm goes straight to the final result with nothing held
  `ADTT_ASSERT_NEXT(a_arm_emit, clk, rst_n,
    in_acc && (in_req_type == adtt_pkg::REQ_ARM),
    (state_r == ST_EMIT) && !pend_v_r)
  // a stalled check keeps its slot
  `ADTT_ASSERT_NEXT(a_stall_hold, clk, rst_n,
    (state_r == ST_SCAN) && blk, chk_v_r && $stable(chk_idx_r))

endmodule
